### src/binary_min_heap_queue_top_defines.svh
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off while arst_n is low.
`define BMHQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication, clocked on clk, off while arst_n is low.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define BMHQ_ASSERT_SAME(lbl, ante, cons)
`define BMHQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/bmhq_pkg.sv
// Shared constants and types of the binary min-heap queue.
`default_nettype none
package bmhq_pkg;
	localparam int HEAP_DEPTH        = 64;
	localparam int HEAP_PAYLOAD_BITS = 32;
	localparam int PRIO_BITS         = 32;
	localparam int PAY_PORT_BITS     = 32;
	localparam int COUNT_PORT_BITS   = 7;
	localparam int CAP_BITS          = 7;
	localparam int STATUS_BITS       = 2;
	localparam int S_DATA_BITS       = PAY_PORT_BITS + PRIO_BITS;
	localparam int M_DATA_BITS       = 40;
	localparam int M_PAD_BITS        = M_DATA_BITS - PAY_PORT_BITS - COUNT_PORT_BITS;
	localparam int APB_ADDR_BITS     = 3;
	localparam int APB_DATA_BITS     = 32;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
	localparam logic                REG_CAP   = 1'b0;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;
endpackage
`default_nettype wire

### src/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### src/bmhq_cmp.sv
// Shared signed priority comparator.
`default_nettype none
module bmhq_cmp
	import bmhq_pkg::*;
(
	input  wire logic signed [PRIO_BITS-1:0] a,
	input  wire logic signed [PRIO_BITS-1:0] b,
	output cmp_res_t                         res
);
	assign res.lt = (a < b);
	assign res.eq = (a == b);
endmodule
`default_nettype wire

### src/bmhq_ctrl.sv
// Sequencer that runs push sift-up and pop sift-down over the heap RAM.
`default_nettype none
module bmhq_ctrl
	import bmhq_pkg::*;
#(
	parameter int DEPTH        = HEAP_DEPTH,
	parameter int PAYLOAD_BITS = HEAP_PAYLOAD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [CAP_BITS-1:0]                 cap_limit,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [S_DATA_BITS-1:0]              s_tdata,
	input  wire logic [0:0]                          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [M_DATA_BITS-1:0]              m_tdata,
	output logic      [STATUS_BITS-1:0]              m_tuser,
	output logic      [$clog2(DEPTH+1)-1:0]          count,
	output logic                                     busy,
	output logic                                     ram_we,
	output logic      [$clog2(DEPTH)-1:0]            ram_waddr,
	output logic      [PRIO_BITS+PAYLOAD_BITS-1:0]   ram_wdata,
	output logic                                     ram_re,
	output logic      [$clog2(DEPTH)-1:0]            ram_raddr,
	input  wire logic [PRIO_BITS+PAYLOAD_BITS-1:0]   ram_rdata,
	output logic      [PRIO_BITS-1:0]                cmp_a,
	output logic      [PRIO_BITS-1:0]                cmp_b,
	input  cmp_res_t                                 cmp_res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = AW + 2;
	localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;
	localparam int EW = PRIO_BITS + PAYLOAD_BITS;
	localparam int PB = PAYLOAD_BITS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP_RD  = 4'd1;
	localparam logic [3:0] S_UP_CMP = 4'd2;
	localparam logic [3:0] S_UP_FIN = 4'd3;
	localparam logic [3:0] S_P_ROOT = 4'd4;
	localparam logic [3:0] S_P_LAST = 4'd5;
	localparam logic [3:0] S_DN_A   = 4'd6;
	localparam logic [3:0] S_DN_B   = 4'd7;
	localparam logic [3:0] S_DN_C   = 4'd8;
	localparam logic [3:0] S_DN_D   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]             state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          pos_q, pos_d;
	logic [EW-1:0]          item_q, item_d;
	logic [EW-1:0]          lc_ent_q, lc_ent_d;
	logic [EW-1:0]          rc_ent_q, rc_ent_d;
	logic                   me_lt_l_q, me_lt_l_d;
	logic [PB-1:0]          res_pay_q, res_pay_d;
	logic [STATUS_BITS-1:0] res_st_q, res_st_d;

	logic                       m_tvalid_q;
	logic [PAY_PORT_BITS-1:0]   m_pay_q;
	logic [STATUS_BITS-1:0]     m_st_q;
	logic [COUNT_PORT_BITS-1:0] m_cnt_q;

	logic [PRIO_BITS-1:0] item_prio, rd_prio, lc_prio, rc_prio;
	logic [AW-1:0]        parent, lc_a, rc_a;
	logic [XW-1:0]        lc_x, rc_x, len_x;
	logic [CW-1:0]        count_m1;
	logic [LW-1:0]        limit_w, depth_w, cap_w;
	logic                 full, out_free;

	assign item_prio = item_q[EW-1:PB];
	assign rd_prio   = ram_rdata[EW-1:PB];
	assign lc_prio   = lc_ent_q[EW-1:PB];
	assign rc_prio   = rc_ent_q[EW-1:PB];

	// Children of slot p sit at 2p+1 and 2p+2, the parent at (p-1)/2.
	assign parent   = AW'((pos_q - AW'(1)) >> 1);
	assign lc_x     = {1'b0, pos_q, 1'b1};
	assign rc_x     = lc_x + XW'(1);
	assign len_x    = XW'(count_q);
	assign lc_a     = lc_x[AW-1:0];
	assign rc_a     = rc_x[AW-1:0];
	assign count_m1 = count_q - CW'(1);

	// The limit saturates at the heap depth.
	assign limit_w = LW'(cap_limit);
	assign depth_w = LW'(DEPTH);
	assign cap_w   = (limit_w > depth_w) ? depth_w : limit_w;
	assign full    = (LW'(count_q) >= cap_w);

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign count    = count_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		item_d    = item_q;
		lc_ent_d  = lc_ent_q;
		rc_ent_d  = rc_ent_q;
		me_lt_l_d = me_lt_l_q;
		res_pay_d = res_pay_q;
		res_st_d  = res_st_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = item_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		cmp_a     = item_prio;
		cmp_b     = rd_prio;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					res_pay_d = '0;
					res_st_d  = STAT_OK;
					if (s_tuser[0] == ACT_PUSH) begin
						if (full) begin
							res_st_d = STAT_FULL;
							state_d  = S_DONE;
						end else begin
							item_d  = {s_tdata[S_DATA_BITS-1:PAY_PORT_BITS],
								PB'(s_tdata[PAY_PORT_BITS-1:0])};
							pos_d   = count_q[AW-1:0];
							count_d = count_q + CW'(1);
							state_d = (count_q == '0) ? S_UP_FIN : S_UP_RD;
						end
					end else if (count_q == '0) begin
						res_st_d = STAT_EMPTY;
						state_d  = S_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = S_P_ROOT;
					end
				end
			end
			S_UP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = parent;
				state_d   = S_UP_CMP;
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cmp_res.lt) begin
					// The parent moves down into the hole.
					ram_wdata = ram_rdata;
					pos_d     = parent;
					state_d   = (parent == '0) ? S_UP_FIN : S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UP_FIN: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end
			S_P_ROOT: begin
				res_pay_d = ram_rdata[PB-1:0];
				ram_re    = 1'b1;
				ram_raddr = count_m1[AW-1:0];
				count_d   = count_m1;
				state_d   = S_P_LAST;
			end
			S_P_LAST: begin
				// The last entry walks down from the root.
				item_d  = ram_rdata;
				pos_d   = '0;
				state_d = (count_q == '0) ? S_DONE : S_DN_A;
			end
			S_DN_A: begin
				if (lc_x < len_x) begin
					ram_re    = 1'b1;
					ram_raddr = lc_a;
					state_d   = S_DN_B;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_B: begin
				lc_ent_d  = ram_rdata;
				me_lt_l_d = cmp_res.lt;
				if (rc_x < len_x) begin
					ram_re    = 1'b1;
					ram_raddr = rc_a;
					state_d   = S_DN_C;
				end else if (!cmp_res.lt && !cmp_res.eq) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					pos_d     = lc_a;
					state_d   = S_DN_A;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_C: begin
				rc_ent_d = ram_rdata;
				// When only one of the two compares holds, the smaller child is known.
				priority if (me_lt_l_q && cmp_res.lt) begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end else if (me_lt_l_q) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					pos_d     = rc_a;
					state_d   = S_DN_A;
				end else if (cmp_res.lt) begin
					ram_we    = 1'b1;
					ram_wdata = lc_ent_q;
					pos_d     = lc_a;
					state_d   = S_DN_A;
				end else begin
					state_d = S_DN_D;
				end
			end
			S_DN_D: begin
				cmp_a  = lc_prio;
				cmp_b  = rc_prio;
				ram_we = 1'b1;
				if (cmp_res.lt) begin
					ram_wdata = lc_ent_q;
					pos_d     = lc_a;
				end else begin
					ram_wdata = rc_ent_q;
					pos_d     = rc_a;
				end
				state_d = S_DN_A;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		item_q    <= item_d;
		lc_ent_q  <= lc_ent_d;
		rc_ent_q  <= rc_ent_d;
		me_lt_l_q <= me_lt_l_d;
		res_pay_q <= res_pay_d;
		res_st_q  <= res_st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_pay_q <= PAY_PORT_BITS'(res_pay_q);
			m_st_q  <= res_st_q;
			m_cnt_q <= COUNT_PORT_BITS'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_BITS{1'b0}}, m_cnt_q, m_pay_q};
	assign m_tuser  = m_st_q;
endmodule
`default_nettype wire

### src/binary_min_heap_queue_top.sv
// Top level of the binary min-heap priority queue: register port and datapath.
//
//  channel | direction | handshake                | contents
//  s_*     | in        | s_tvalid / s_tready      | tdata: payload_in, priority_in; tuser: action
//  m_*     | out       | m_tvalid / m_tready      | tdata: payload_out, count_after; tuser: status
//  apb     | in        | psel, penable, pready=1  | capacity_limit at address 0
//
// A refused push or pop goes straight to the result state. An accepted push climbs one
// level at a time toward the root, and an accepted pop walks the last entry down one level
// at a time, both through the one RAM read port and the shared comparator. A finished item
// holds in the result state until the output register is free, and no new item is taken
// before that. Reset empties the heap and sets the limit to 64; the RAM needs no clearing.
`default_nettype none
`include "binary_min_heap_queue_top_defines.svh"
module binary_min_heap_queue_top
	import bmhq_pkg::*;
#(
	parameter int DEPTH        = HEAP_DEPTH,
	parameter int PAYLOAD_BITS = HEAP_PAYLOAD_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// payload_in [31:0], priority_in [63:32]
	input  wire logic [S_DATA_BITS-1:0]   s_tdata,
	// action [0]
	input  wire logic [0:0]               s_tuser,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// payload_out [31:0], count_after [38:32], zero [39]
	output logic      [M_DATA_BITS-1:0]   m_tdata,
	// status [1:0]
	output logic      [STATUS_BITS-1:0]   m_tuser,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = PRIO_BITS + PAYLOAD_BITS;

	logic [CAP_BITS-1:0] cap_q;
	logic                reg_sel;
	logic                cfg_wr;
	logic [CW-1:0]       count_w;
	logic                busy_w;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [EW-1:0]       ram_wdata, ram_rdata;
	logic [PRIO_BITS-1:0] cmp_a, cmp_b;
	cmp_res_t            cmp_res;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_CAP);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = reg_sel ? APB_DATA_BITS'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && reg_sel) begin
			cap_q <= pwdata[CAP_BITS-1:0];
		end
	end

	bmhq_ctrl #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_limit (cap_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.count     (count_w),
		.busy      (busy_w),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_res   (cmp_res)
	);

	bmhq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bmhq_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// The entry count never exceeds the heap depth.
	`BMHQ_ASSERT_SAME(a_count_bound, 1'b1, count_w <= CW'(DEPTH))
	// An accepted item keeps the sequencer busy for at least the next cycle.
	`BMHQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, busy_w && !s_tready)
	// While busy, the count stays or drops by one entry.
	`BMHQ_ASSERT_NEXT(a_count_step, busy_w, CW'($past(count_w) - count_w) <= CW'(1))
endmodule
`default_nettype wire
